### design/assert_macros.svh
// Assertion macros shared by the limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define SLPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication under reset.
`define SLPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`else

`define SLPL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLPL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/slpl_pkg.sv
// Types and constants of the stereo linked peak limiter.
`timescale 1ns / 1ps
package slpl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 25;
    localparam int COEF_W   = 24;
    localparam int RISE_W   = 25;
    localparam int ENV_W    = 28;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 5;
    localparam int LOW_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;

    typedef enum logic [2:0] {
        REG_INPUT_GAIN     = 3'd0,
        REG_RELEASE_COEF   = 3'd1,
        REG_SMOOTH_COEF    = 3'd2,
        REG_LINK_RISE_COEF = 3'd3,
        REG_SMOOTHING_MODE = 3'd4
    } reg_idx_t;

    localparam logic [COEF_W-1:0] INPUT_GAIN_RST   = 24'd1048576;
    localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 24'd16775945;
    localparam logic [COEF_W-1:0] SMOOTH_COEF_RST  = 24'd16747062;
    localparam logic [RISE_W-1:0] LINK_RISE_RST    = 25'd16786876;

    localparam logic [ENV_W-1:0]  THRESH_Q24 = 28'd16585169;
    localparam logic [GAIN_W-1:0] UNITY_Q24  = 25'd16777216;

    localparam logic [CNT_W-1:0] MUL_LAST = 5'd24;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd23;

endpackage

### design/slpl_stream_if.sv
// Valid/ready stream interfaces for sample pairs and limited results.
`timescale 1ns / 1ps
interface slpl_in_if;
    import slpl_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface slpl_out_if;
    import slpl_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    gain_t   left_gain;
    gain_t   right_gain;

    modport source (output valid, output left_out, output right_out,
                    output left_gain, output right_gain, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input left_gain, input right_gain, output ready);
endinterface

### design/stereo_linked_peak_limiter_core.sv
// Stereo linked peak limiter with one shared bit-serial multiply/divide unit.
//
//   channel   kind        width                    handshake
//   sample    stream in   2 x 24 signed            valid/ready
//   result    stream out  2 x 24 signed, 2 x 25    valid/ready
//   apb       config      32 data, 5 addr          psel/penable, pready tied high
//
// Each item is worked through step by step in the shared serial unit, which
// multiplies one multiplier bit a cycle and also does the divide.
// Smoother, release, link and divide steps are skipped when not needed.
// Reset clears all envelopes and loads register defaults; no clearing pass.
// A new item is taken while the previous result waits; a stalled result
// holds the finished item in its last state until the output frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stereo_linked_peak_limiter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    slpl_in_if.sink                         sample,
    slpl_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slpl_pkg::ADDR_W-1:0]     paddr,
    input  logic [slpl_pkg::DATA_W-1:0]     pwdata,
    output logic [slpl_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import slpl_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MAG    = 9'b000000010,
        ST_SMOOTH = 9'b000000100,
        ST_ENV    = 9'b000001000,
        ST_LINK   = 9'b000010000,
        ST_RAISE  = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_OUT    = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    // configuration
    logic [COEF_W-1:0] input_gain_reg;
    logic [COEF_W-1:0] release_coef_reg;
    logic [COEF_W-1:0] smooth_coef_reg;
    logic [RISE_W-1:0] link_rise_reg;
    logic              smoothing_mode_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // sequencer
    state_t             state_reg, state_next;
    logic               side_reg, side_next;
    logic               run_reg, run_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // serial unit
    logic [ENV_W-1:0]   mcand_reg, mcand_next;
    logic [GAIN_W-1:0]  mplier_reg, mplier_next;
    logic [ENV_W-1:0]   acc_reg, acc_next;
    logic [LOW_W-1:0]   low_reg, low_next;

    // item and channel state
    logic               neg_l_reg, neg_l_next, neg_r_reg, neg_r_next;
    logic [SAMPLE_W-1:0] abs_l_reg, abs_l_next, abs_r_reg, abs_r_next;
    logic [ENV_W-1:0]   m_l_reg, m_l_next, m_r_reg, m_r_next;
    logic [ENV_W-1:0]   smooth_l_reg, smooth_l_next, smooth_r_reg, smooth_r_next;
    logic [ENV_W-1:0]   env_l_reg, env_l_next, env_r_reg, env_r_next;
    logic [ENV_W-1:0]   env_lk_reg, env_lk_next;
    logic [GAIN_W-1:0]  gain_l_reg, gain_l_next, gain_r_reg, gain_r_next;
    logic [SAMPLE_W-1:0] lim_l_reg, lim_l_next, lim_r_reg, lim_r_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [SAMPLE_W-1:0] left_out_reg, right_out_reg;
    logic [GAIN_W-1:0]  left_gain_reg, right_gain_reg;

    // datapath
    logic [ENV_W:0]     mul_sum;
    logic [ENV_W-1:0]   mul_acc;
    logic [LOW_W-1:0]   mul_low;
    logic [ENV_W+LOW_W-1:0] res_wide;
    logic [ENV_W-1:0]   mul_res;
    logic [ENV_W:0]     div_trial;
    logic [ENV_W:0]     div_diff;
    logic               div_ge;
    logic [ENV_W-1:0]   div_rem;
    logic [GAIN_W-1:0]  div_quot;
    logic               mul_step, div_step, mul_done, div_done;

    logic [ENV_W-1:0]   cur_m, cur_s, cur_env, cur_d, target, lk_plus, link_up;
    logic [SAMPLE_W-1:0] cur_abs;
    logic [GAIN_W-1:0]  cur_gain;
    logic               cur_neg;
    logic               accept;

    function automatic logic [SAMPLE_W-1:0] saturate(input logic [ENV_W-1:0] q,
                                                     input logic neg);
        logic [ENV_W-1:0] neg_q;
        neg_q = '0 - q;
        if (neg)
        begin
            return (q > 28'd8388608) ? 24'h800000 : neg_q[SAMPLE_W-1:0];
        end
        return (q > 28'd8388607) ? 24'h7FFFFF : q[SAMPLE_W-1:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg     <= INPUT_GAIN_RST;
            release_coef_reg   <= RELEASE_COEF_RST;
            smooth_coef_reg    <= SMOOTH_COEF_RST;
            link_rise_reg      <= LINK_RISE_RST;
            smoothing_mode_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_INPUT_GAIN:     input_gain_reg     <= pwdata[COEF_W-1:0];
                REG_RELEASE_COEF:   release_coef_reg   <= pwdata[COEF_W-1:0];
                REG_SMOOTH_COEF:    smooth_coef_reg    <= pwdata[COEF_W-1:0];
                REG_LINK_RISE_COEF: link_rise_reg      <= pwdata[RISE_W-1:0];
                REG_SMOOTHING_MODE: smoothing_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_INPUT_GAIN:     prdata = {8'd0, input_gain_reg};
            REG_RELEASE_COEF:   prdata = {8'd0, release_coef_reg};
            REG_SMOOTH_COEF:    prdata = {8'd0, smooth_coef_reg};
            REG_LINK_RISE_COEF: prdata = {7'd0, link_rise_reg};
            REG_SMOOTHING_MODE: prdata = {31'd0, smoothing_mode_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- serial datapath ----------------
    assign mul_sum  = {1'b0, acc_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_acc  = mul_sum[ENV_W:1];
    assign mul_low  = {mul_sum[0], low_reg[LOW_W-1:1]};
    assign res_wide = {mul_acc, mul_low};

    // product >> 19 for magnitudes, >> 25 for output, >> 24 for coefficients
    always_comb
    begin
        if (state_reg == ST_MAG)
        begin
            mul_res = res_wide[ENV_W:1];
        end
        else if (state_reg == ST_OUT)
        begin
            mul_res = res_wide[ENV_W+LOW_W-1:LOW_W];
        end
        else
        begin
            mul_res = res_wide[ENV_W+LOW_W-2:LOW_W-1];
        end
    end

    // restoring divide, one quotient bit a cycle
    assign div_trial = {acc_reg, 1'b0};
    assign div_diff  = div_trial - {1'b0, mcand_reg};
    assign div_ge    = (div_trial >= {1'b0, mcand_reg});
    assign div_rem   = div_ge ? div_diff[ENV_W-1:0] : div_trial[ENV_W-1:0];
    assign div_quot  = {mplier_reg[GAIN_W-2:0], div_ge};

    assign mul_step = run_reg && (state_reg != ST_DIV);
    assign div_step = run_reg && (state_reg == ST_DIV);
    assign mul_done = mul_step && (cnt_reg == MUL_LAST);
    assign div_done = div_step && (cnt_reg == DIV_LAST);

    assign cur_m    = side_reg ? m_r_reg      : m_l_reg;
    assign cur_s    = side_reg ? smooth_r_reg : smooth_l_reg;
    assign cur_env  = side_reg ? env_r_reg    : env_l_reg;
    assign cur_abs  = side_reg ? abs_r_reg    : abs_l_reg;
    assign cur_gain = side_reg ? gain_r_reg   : gain_l_reg;
    assign cur_neg  = side_reg ? neg_r_reg    : neg_l_reg;
    assign cur_d    = smoothing_mode_reg ? cur_s : cur_m;
    assign target   = (env_l_reg > env_r_reg) ? env_l_reg : env_r_reg;
    assign lk_plus  = env_lk_reg + 28'd1;
    assign link_up  = (mul_res < lk_plus) ? lk_plus : mul_res;

    assign accept   = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        low_next       = low_reg;
        neg_l_next     = neg_l_reg;
        neg_r_next     = neg_r_reg;
        abs_l_next     = abs_l_reg;
        abs_r_next     = abs_r_reg;
        m_l_next       = m_l_reg;
        m_r_next       = m_r_reg;
        smooth_l_next  = smooth_l_reg;
        smooth_r_next  = smooth_r_reg;
        env_l_next     = env_l_reg;
        env_r_next     = env_r_reg;
        env_lk_next    = env_lk_reg;
        gain_l_next    = gain_l_reg;
        gain_r_next    = gain_r_reg;
        lim_l_next     = lim_l_reg;
        lim_r_next     = lim_r_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;

        if (mul_step)
        begin
            acc_next    = mul_acc;
            low_next    = mul_low;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
        end
        if (div_step)
        begin
            acc_next    = div_rem;
            mplier_next = div_quot;
            cnt_next    = cnt_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_l_next = sample.left_in[SAMPLE_W-1];
                    neg_r_next = sample.right_in[SAMPLE_W-1];
                    abs_l_next = sample.left_in[SAMPLE_W-1] ? -sample.left_in
                                                            : sample.left_in;
                    abs_r_next = sample.right_in[SAMPLE_W-1] ? -sample.right_in
                                                             : sample.right_in;
                    side_next  = 1'b0;
                    run_next   = 1'b0;
                    state_next = ST_MAG;
                end
            end

            ST_MAG:
            begin
                if (!run_reg)
                begin
                    mcand_next  = {4'd0, cur_abs};
                    mplier_next = {1'b0, input_gain_reg};
                    acc_next    = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (mul_done)
                begin
                    run_next = 1'b0;
                    if (side_reg)
                    begin
                        m_r_next   = mul_res;
                        side_next  = 1'b0;
                        state_next = smoothing_mode_reg ? ST_SMOOTH : ST_ENV;
                    end
                    else
                    begin
                        m_l_next  = mul_res;
                        side_next = 1'b1;
                    end
                end
            end

            ST_SMOOTH:
            begin
                if (!run_reg && (cur_s < cur_m))
                begin
                    // instant attack
                    if (side_reg)
                    begin
                        smooth_r_next = cur_m;
                        state_next    = ST_ENV;
                    end
                    else
                    begin
                        smooth_l_next = cur_m;
                    end
                    side_next = !side_reg;
                end
                else if (!run_reg)
                begin
                    mcand_next  = cur_s - cur_m;
                    mplier_next = {1'b0, smooth_coef_reg};
                    acc_next    = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (mul_done)
                begin
                    run_next = 1'b0;
                    if (side_reg)
                    begin
                        smooth_r_next = cur_m + mul_res;
                        state_next    = ST_ENV;
                    end
                    else
                    begin
                        smooth_l_next = cur_m + mul_res;
                    end
                    side_next = !side_reg;
                end
            end

            ST_ENV:
            begin
                if (!run_reg && (cur_env < cur_d))
                begin
                    if (side_reg)
                    begin
                        env_r_next = cur_d;
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        env_l_next = cur_d;
                    end
                    side_next = !side_reg;
                end
                else if (!run_reg)
                begin
                    mcand_next  = cur_env;
                    mplier_next = {1'b0, release_coef_reg};
                    acc_next    = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (mul_done)
                begin
                    run_next = 1'b0;
                    if (side_reg)
                    begin
                        env_r_next = (mul_res > cur_d) ? mul_res : cur_d;
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        env_l_next = (mul_res > cur_d) ? mul_res : cur_d;
                    end
                    side_next = !side_reg;
                end
            end

            ST_LINK:
            begin
                if (!run_reg && (env_lk_reg >= target))
                begin
                    // fall at once
                    env_lk_next = target;
                    state_next  = ST_RAISE;
                end
                else if (!run_reg)
                begin
                    mcand_next  = env_lk_reg;
                    mplier_next = link_rise_reg;
                    acc_next    = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (mul_done)
                begin
                    // rise by the coefficient, at least one LSB, capped at target
                    run_next    = 1'b0;
                    env_lk_next = (link_up < target) ? link_up : target;
                    state_next  = ST_RAISE;
                end
            end

            ST_RAISE:
            begin
                env_l_next = (env_l_reg < env_lk_reg) ? env_lk_reg : env_l_reg;
                env_r_next = (env_r_reg < env_lk_reg) ? env_lk_reg : env_r_reg;
                side_next  = 1'b0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (!run_reg && (cur_env <= THRESH_Q24))
                begin
                    if (side_reg)
                    begin
                        gain_r_next = UNITY_Q24;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        gain_l_next = UNITY_Q24;
                    end
                    side_next = !side_reg;
                end
                else if (!run_reg)
                begin
                    // dividend is threshold << 24; the top part seeds the remainder
                    mcand_next  = cur_env;
                    acc_next    = THRESH_Q24;
                    mplier_next = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (div_done)
                begin
                    run_next = 1'b0;
                    if (side_reg)
                    begin
                        gain_r_next = {1'b0, div_quot[GAIN_W-2:0]};
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        gain_l_next = {1'b0, div_quot[GAIN_W-2:0]};
                    end
                    side_next = !side_reg;
                end
            end

            ST_OUT:
            begin
                if (!run_reg)
                begin
                    mcand_next  = cur_m;
                    mplier_next = cur_gain;
                    acc_next    = '0;
                    cnt_next    = '0;
                    run_next    = 1'b1;
                end
                else if (mul_done)
                begin
                    run_next = 1'b0;
                    if (side_reg)
                    begin
                        lim_r_next = saturate(mul_res, cur_neg);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        lim_l_next = saturate(mul_res, cur_neg);
                    end
                    side_next = !side_reg;
                end
            end

            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    side_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                run_next   = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= 1'b0;
            run_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            smooth_l_reg  <= '0;
            smooth_r_reg  <= '0;
            env_l_reg     <= '0;
            env_r_reg     <= '0;
            env_lk_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            smooth_l_reg  <= smooth_l_next;
            smooth_r_reg  <= smooth_r_next;
            env_l_reg     <= env_l_next;
            env_r_reg     <= env_r_next;
            env_lk_reg    <= env_lk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        low_reg    <= low_next;
        neg_l_reg  <= neg_l_next;
        neg_r_reg  <= neg_r_next;
        abs_l_reg  <= abs_l_next;
        abs_r_reg  <= abs_r_next;
        m_l_reg    <= m_l_next;
        m_r_reg    <= m_r_next;
        gain_l_reg <= gain_l_next;
        gain_r_reg <= gain_r_next;
        lim_l_reg  <= lim_l_next;
        lim_r_reg  <= lim_r_next;
        if (out_load)
        begin
            left_out_reg   <= lim_l_reg;
            right_out_reg  <= lim_r_reg;
            left_gain_reg  <= gain_l_reg;
            right_gain_reg <= gain_r_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.left_out   = left_out_reg;
    assign result.right_out  = right_out_reg;
    assign result.left_gain  = left_gain_reg;
    assign result.right_gain = right_gain_reg;

    // ---------------- assertions ----------------
    `SLPL_ASSERT_NXT(a_accept_starts_mag, clk, rst_n, accept, state_reg == ST_MAG && !run_reg)
    `SLPL_ASSERT_IMP(a_div_rem_below, clk, rst_n, div_step, acc_reg < mcand_reg)
    `SLPL_ASSERT_IMP(a_link_under_env, clk, rst_n, state_reg == ST_DIV, env_lk_reg <= env_l_reg && env_lk_reg <= env_r_reg)
    `SLPL_ASSERT_IMP(a_gain_max_unity, clk, rst_n, state_reg == ST_OUT, cur_gain <= UNITY_Q24)

endmodule
